/* rtl/core/rrjq_pkg.sv */
`timescale 1ns / 1ps

package rrjq_pkg;

    localparam int ID_W        = 16;
    localparam int LIFE_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int LIMIT_W     = 5;
    localparam int QUANTUM_W   = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int SLOT_W      = ID_W + LIFE_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ENQUEUED = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_SERVED   = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        ACT_PRODUCE = 1'b0,
        ACT_CONSUME = 1'b1
    } action_t;

    typedef enum logic {
        MODE_FCFS = 1'b0,
        MODE_RR   = 1'b1
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'b01,
        FSM_SERVE = 2'b10
    } fsm_t;

endpackage

/* rtl/core/rrjq_ram.sv */
`timescale 1ns / 1ps

module rrjq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/round_robin_job_queue.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Contents
// s_       in   s_tvalid/s_tready  tuser: action; tdata: job_id, job_life
// m_       out  m_tvalid/m_tready  tuser: status; tdata: id, units, done, count
// cfg_     in   cfg_wr_en          cfg_index selects queue_limit, mode, quantum
//
// A produce transfer, or a consume on an empty queue, registers its result
// in FSM_IDLE. A consume that serves a job goes through FSM_SERVE: the registered
// slot memory read of the head entry returns there, then the result is formed
// and a requeued job is written back at the tail. One job is handled at a time.
// Synchronous active-low reset clears state, pointers, count, valid flag and config;
// payload and slot memory need no clearing pass. A stalled result holds s_tready low.

module round_robin_job_queue
    import rrjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] job_id, [25:16] job_life, rest 0
    input  logic                  s_tuser,   // [0] action

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] served_id, [25:16] served_units,
                                             // [26] job_done, [31:27] queue_count
    output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

    // configuration
    logic [LIMIT_W-1:0]   queue_limit_reg;
    mode_t                mode_reg;
    logic [QUANTUM_W-1:0] quantum_reg;

    // control state
    fsm_t             fsm_reg, fsm_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // result payload
    status_t               status_reg, status_next;
    logic [ID_W-1:0]       sid_reg, sid_next;
    logic [LIFE_W-1:0]     units_reg, units_next;
    logic                  done_reg, done_next;
    logic [COUNT_OUT_W-1:0] qcount_reg, qcount_next;

    // memory ports
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_wr_addr;
    logic [SLOT_W-1:0] mem_wr_data;
    logic [SLOT_W-1:0] mem_rd_data;

    logic              in_xfer;
    action_t           in_action;
    logic [ID_W-1:0]   in_id;
    logic [LIFE_W-1:0] in_life;
    logic [CMP_W-1:0]  limit_cmp;
    logic [CMP_W-1:0]  eff_limit;
    logic [CMP_W-1:0]  count_cmp;
    logic [ID_W-1:0]   head_id;
    logic [LIFE_W-1:0] head_life;
    logic [LIFE_W-1:0] grant;
    logic [LIFE_W-1:0] left;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    rrjq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data)
    );

    assign s_tready  = (fsm_reg == FSM_IDLE) && (!m_valid_reg || m_tready);
    assign in_xfer   = s_tvalid && s_tready;
    assign in_action = action_t'(s_tuser);
    assign in_id     = s_tdata[ID_W-1:0];
    assign in_life   = s_tdata[ID_W+LIFE_W-1:ID_W];

    assign limit_cmp = CMP_W'(queue_limit_reg);
    assign eff_limit = (limit_cmp == '0 || limit_cmp > DEPTH_CMP) ? DEPTH_CMP : limit_cmp;
    assign count_cmp = CMP_W'(count_reg);

    assign head_id   = mem_rd_data[ID_W-1:0];
    assign head_life = mem_rd_data[SLOT_W-1:ID_W];

    always_comb begin
        if (mode_reg == MODE_FCFS) begin
            grant = head_life;
        end else begin
            grant = (head_life < quantum_reg) ? head_life : quantum_reg;
        end
        left = head_life - grant;
    end

    always_comb begin
        fsm_next     = fsm_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        sid_next     = sid_reg;
        units_next   = units_reg;
        done_next    = done_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = tail_reg;
        mem_wr_data  = {in_life, in_id};

        unique case (fsm_reg)
            FSM_IDLE: begin
                if (in_xfer) begin
                    sid_next   = '0;
                    units_next = '0;
                    done_next  = 1'b0;
                    if (in_action == ACT_PRODUCE) begin
                        m_valid_next = 1'b1;
                        if (count_cmp >= eff_limit) begin
                            status_next = STATUS_REJECTED;
                        end else begin
                            status_next = STATUS_ENQUEUED;
                            mem_wr_en   = 1'b1;
                            tail_next   = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end else if (count_reg == '0) begin
                        m_valid_next = 1'b1;
                        status_next  = STATUS_EMPTY;
                    end else begin
                        // head entry read is in flight
                        fsm_next = FSM_SERVE;
                    end
                end
            end
            FSM_SERVE: begin
                fsm_next     = FSM_IDLE;
                m_valid_next = 1'b1;
                status_next  = STATUS_SERVED;
                sid_next     = head_id;
                units_next   = grant;
                head_next    = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                if (left == '0) begin
                    done_next  = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    // requeue the remainder at the tail
                    done_next   = 1'b0;
                    mem_wr_en   = 1'b1;
                    mem_wr_data = {left, head_id};
                    tail_next   = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase
    end

    assign count_ext   = {{COUNT_OUT_W{1'b0}}, count_next};
    assign qcount_next = count_ext[COUNT_OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg         <= FSM_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
            queue_limit_reg <= '0;
            mode_reg        <= MODE_FCFS;
            quantum_reg     <= QUANTUM_W'(1);
        end else begin
            fsm_reg     <= fsm_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                    CFG_MODE:        mode_reg        <= mode_t'(cfg_wr_data[0]);
                    CFG_QUANTUM:     quantum_reg     <= cfg_wr_data[QUANTUM_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        sid_reg    <= sid_next;
        units_reg  <= units_next;
        done_reg   <= done_next;
        if (m_valid_next && !(m_valid_reg && !m_tready)) begin
            qcount_reg <= qcount_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {qcount_reg, done_reg, units_reg, sid_reg};

endmodule

/* tb/round_robin_job_queue_test.sv */
`timescale 1ns / 1ps

module round_robin_job_queue_test;
    import rrjq_pkg::*;

    localparam int DEPTH           = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        status_t                  status;
        logic [ID_W-1:0]          id;
        logic [LIFE_W-1:0]        units;
        logic                     done;
        logic [COUNT_OUT_W-1:0]   held;
    } job_result_t;

    class job_queue_board;
        logic [ID_W-1:0]      slot_id [DEPTH];
        logic [LIFE_W-1:0]    slot_life [DEPTH];
        int unsigned          head, tail, held;
        logic [LIMIT_W-1:0]   limit_reg;
        mode_t                mode_reg;
        logic [QUANTUM_W-1:0] quantum_reg;
        job_result_t          expected_results [$];
        int errors, n_jobs, n_results, n_rejected, n_empty, n_requeued, n_finished;

        function new();
            head = 0;
            tail = 0;
            held = 0;
            limit_reg = '0;
            mode_reg = MODE_FCFS;
            quantum_reg = QUANTUM_W'(1);
            errors = 0;
            n_jobs = 0;
            n_results = 0;
            n_rejected = 0;
            n_empty = 0;
            n_requeued = 0;
            n_finished = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_QUEUE_LIMIT: limit_reg = val[LIMIT_W-1:0];
                CFG_MODE:        mode_reg = mode_t'(val[0]);
                CFG_QUANTUM:     quantum_reg = val[QUANTUM_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Advance the queue by one accepted transfer and store the result it must produce.
        function void note_input(action_t act, logic [ID_W-1:0] id, logic [LIFE_W-1:0] life);
            job_result_t r;
            int unsigned cap;
            logic [LIFE_W-1:0] left;
            r = '{status: STATUS_ENQUEUED, id: '0, units: '0, done: 1'b0, held: '0};
            cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
            n_jobs++;
            if (act == ACT_PRODUCE) begin
                if (held >= cap) begin
                    r.status = STATUS_REJECTED;
                    n_rejected++;
                end else begin
                    slot_id[tail] = id;
                    slot_life[tail] = life;
                    tail = (tail + 1) % DEPTH;
                    held++;
                end
            end else if (held == 0) begin
                r.status = STATUS_EMPTY;
                n_empty++;
            end else begin
                r.status = STATUS_SERVED;
                r.id = slot_id[head];
                left = slot_life[head];
                head = (head + 1) % DEPTH;
                if (mode_reg == MODE_FCFS)
                    r.units = left;
                else
                    r.units = (left < quantum_reg) ? left : quantum_reg;
                left = left - r.units;
                if (left == 0) begin
                    r.done = 1'b1;
                    held--;
                    n_finished++;
                end else begin
                    // requeue the remainder at the tail
                    slot_id[tail] = r.id;
                    slot_life[tail] = left;
                    tail = (tail + 1) % DEPTH;
                    n_requeued++;
                end
            end
            r.held = COUNT_OUT_W'(held);
            expected_results.push_back(r);
        endfunction

        function void check_result(job_result_t got);
            job_result_t want;
            if (expected_results.size() == 0) begin
                $error("result with no job pending: status %0d id %0d", got.status, got.id);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            n_results++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.id !== want.id) begin
                $error("served_id: expected %0d, actual %0d", want.id, got.id);
                errors++;
            end
            if (got.units !== want.units) begin
                $error("served_units: expected %0d, actual %0d", want.units, got.units);
                errors++;
            end
            if (got.done !== want.done) begin
                $error("job_done: expected %0d, actual %0d", want.done, got.done);
                errors++;
            end
            if (got.held !== want.held) begin
                $error("queue_count: expected %0d, actual %0d", want.held, got.held);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    job_queue_board board = new();
    int cycles      = 0;
    int rx_pattern  = 1;
    int stall_left  = 0;
    int burst_left  = 0;
    bit tx_gappy    = 1'b1;
    int n_settings  = 0;

    round_robin_job_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL round_robin_job_queue");
        $finish;
    end

    // Receiver: always ready, short random stalls, or long stall runs.
    always @(posedge aclk) begin
        if (!aresetn || rx_pattern == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left <= (rx_pattern == 2) ? $urandom_range(0, 12) : 0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        job_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.id     = m_tdata[15:0];
                got.units  = m_tdata[25:16];
                got.done   = m_tdata[26];
                got.held   = m_tdata[31:27];
                // let the sender record a transfer from the same edge first
                #1;
                board.check_result(got);
            end
        end
    end

    task automatic send_item(input action_t act, input logic [ID_W-1:0] id,
                             input logic [LIFE_W-1:0] life);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, life, id};
        do @(posedge aclk); while (!s_tready);
        board.note_input(act, id, life);
        if (!tx_gappy) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        board.write_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] lim, input mode_t m,
                                 input logic [CFG_DATA_W-1:0] q);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = CFG_DATA_W'($urandom);
        mode_word[0] = m;
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        cfg_write(CFG_QUEUE_LIMIT, lim);
        cfg_write(CFG_MODE, mode_word);
        cfg_write(CFG_QUANTUM, q);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    function automatic logic [LIFE_W-1:0] pick_life();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return LIFE_W'($urandom);
            default: return LIFE_W'($urandom_range(0, 12));
        endcase
    endfunction

    initial begin
        int p, i, produce_pct;
        logic [CFG_DATA_W-1:0] lim, q;
        mode_t m;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: limit 0 means full depth, first-come mode.
        send_item(ACT_CONSUME, ID_W'($urandom), LIFE_W'($urandom));
        send_item(ACT_PRODUCE, 16'h0000, 10'd0);
        send_item(ACT_PRODUCE, 16'hFFFF, 10'h3FF);
        for (i = 0; i < DEPTH - 2; i++)
            send_item(ACT_PRODUCE, ID_W'($urandom), LIFE_W'($urandom_range(1, 20)));
        send_item(ACT_PRODUCE, 16'hA5A5, 10'h155);
        send_item(ACT_CONSUME, ID_W'($urandom), LIFE_W'($urandom));
        send_item(ACT_CONSUME, ID_W'($urandom), LIFE_W'($urandom));
        drain();

        // Round robin with zero quantum: head goes back unchanged.
        apply_setting(10'd0, MODE_RR, 10'd0);
        send_item(ACT_CONSUME, ID_W'($urandom), LIFE_W'($urandom));
        send_item(ACT_CONSUME, ID_W'($urandom), LIFE_W'($urandom));
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lim = 10'd16;  m = MODE_RR;   q = 10'd1;    end
                1: begin lim = 10'd1;   m = MODE_RR;   q = 10'd1023; end
                2: begin lim = 10'd17;  m = MODE_FCFS; q = 10'd0;    end
                3: begin lim = 10'h3FF; m = MODE_RR;   q = 10'd0;    end
                4: begin lim = 10'd4;   m = MODE_RR;   q = 10'd3;    end
                default: begin
                    lim = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(0, 17));
                    m   = mode_t'($urandom_range(0, 1));
                    q   = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(1, 8));
                end
            endcase
            apply_setting(lim, m, q);
            rx_pattern  = p % 3;
            tx_gappy    = (p % 4 != 3);
            produce_pct = $urandom_range(35, 70);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(($urandom_range(0, 99) < produce_pct) ? ACT_PRODUCE : ACT_CONSUME,
                          ID_W'($urandom), pick_life());
            drain();
        end

        $display("run: %0d transfers in, %0d results checked over %0d register settings",
                 board.n_jobs, board.n_results, n_settings);
        $display("seen: %0d rejected, %0d empty consumes, %0d requeued, %0d finished",
                 board.n_rejected, board.n_empty, board.n_requeued, board.n_finished);
        if (board.errors == 0)
            $display("PASS round_robin_job_queue");
        else
            $display("FAIL round_robin_job_queue");
        $finish;
    end

endmodule
